[rtl/cpc_pkg.sv]
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, widths and constants of the cartesian/polar converter.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // field widths of the item payload
  localparam int FIELD_W = 16;
  localparam int ANGLE_W = 32;   // angle accumulator, 2^31 = pi
  localparam int GUARD_W = 4;    // guard fraction bits in the datapath

  // datapath width: 16-bit field, 4 guard bits, CORDIC growth and sign
  localparam int DW = 24;

  // gain removal: round(0.6072529350088813 * 2^24), round half up at bit 28
  localparam int GAIN_W     = 25;
  localparam int PW         = DW + GAIN_W;
  localparam int GAIN_SHIFT = 28;
  localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;

  // defaults of the top-level parameters and the iteration cap
  localparam int COORD_WIDTH_DEF = 16;
  localparam int ITERATIONS_DEF  = 16;
  localparam int MAX_ITERATIONS  = 32;

  // operation codes
  localparam logic OP_TO_POLAR = 1'b0;
  localparam logic OP_TO_RECT  = 1'b1;

  // side-band data that travels with each vector down the chain
  typedef struct packed {
    logic               op;
    logic               zero;    // x and y inputs both zero (used by to_polar)
    logic [FIELD_W-1:0] x_in;
    logic [FIELD_W-1:0] y_in;
    logic [FIELD_W-1:0] mag_in;
    logic [FIELD_W-1:0] angle_in;
  } cpc_tag_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [ANGLE_W-1:0] atan_val(input int i);
    logic [ANGLE_W-1:0] v;
    case (i)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      24:      v = 32'd41;
      25:      v = 32'd20;
      26:      v = 32'd10;
      27:      v = 32'd5;
      28:      v = 32'd3;
      29:      v = 32'd1;
      30:      v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/cpc_if.sv]
// ----------------------------------------------------------------------------
// cpc_in_if / cpc_out_if
// Valid/ready channels carrying one input vector and one result vector.
// ----------------------------------------------------------------------------
interface cpc_in_if;
  import cpc_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [FIELD_W-1:0] x_in;
  logic [FIELD_W-1:0] y_in;
  logic [FIELD_W-1:0] mag_in;
  logic [FIELD_W-1:0] angle_in;

  modport source (output valid, op, x_in, y_in, mag_in, angle_in, input ready);
  modport sink   (input valid, op, x_in, y_in, mag_in, angle_in, output ready);
endinterface

interface cpc_out_if;
  import cpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] x_out;
  logic [FIELD_W-1:0] y_out;
  logic [FIELD_W-1:0] mag_out;
  logic [FIELD_W-1:0] angle_out;

  modport source (output valid, x_out, y_out, mag_out, angle_out, input ready);
  modport sink   (input valid, x_out, y_out, mag_out, angle_out, output ready);
endinterface

[rtl/cpc_pre.sv]
// ----------------------------------------------------------------------------
// cpc_pre
// Input stage: scales the operands and folds them into the right half plane.
// ----------------------------------------------------------------------------
module cpc_pre #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [cpc_pkg::FIELD_W-1:0]      in_x,
  input  logic [cpc_pkg::FIELD_W-1:0]      in_y,
  input  logic [cpc_pkg::FIELD_W-1:0]      in_mag,
  input  logic [cpc_pkg::FIELD_W-1:0]      in_angle,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cpc_pkg::DW-1:0]    out_x,
  output logic signed [cpc_pkg::DW-1:0]    out_y,
  output logic [cpc_pkg::ANGLE_W-1:0]      out_z,
  output cpc_pkg::cpc_tag_t                out_tag
);
  import cpc_pkg::*;

  logic                     valid_r;
  logic signed [DW-1:0]     x_r, x_nxt;
  logic signed [DW-1:0]     y_r, y_nxt;
  logic [ANGLE_W-1:0]       z_r, z_nxt;
  cpc_tag_t                 tag_r, tag_nxt;
  logic signed [DW-1:0]     xe, ye, x16, y16, m16;
  logic                     flip;

  // sign taken from bit COORD_WIDTH-1 of the field; zero-extended if wider
  if (COORD_WIDTH <= FIELD_W) begin : g_sext
    assign xe = DW'($signed(in_x[COORD_WIDTH-1:0]));
    assign ye = DW'($signed(in_y[COORD_WIDTH-1:0]));
  end else begin : g_zext
    assign xe = {{(DW-FIELD_W){1'b0}}, in_x};
    assign ye = {{(DW-FIELD_W){1'b0}}, in_y};
  end

  assign x16  = {xe[DW-GUARD_W-1:0], {GUARD_W{1'b0}}};
  assign y16  = {ye[DW-GUARD_W-1:0], {GUARD_W{1'b0}}};
  assign m16  = {{(DW-FIELD_W-GUARD_W){1'b0}}, in_mag, {GUARD_W{1'b0}}};
  // angle in the second or third quadrant: start at -mag, turn by pi
  assign flip = in_angle[FIELD_W-1] ^ in_angle[FIELD_W-2];

  // operand setup
  always_comb begin
    tag_nxt.op       = in_op;
    tag_nxt.zero     = (xe == '0) && (ye == '0);
    tag_nxt.x_in     = in_x;
    tag_nxt.y_in     = in_y;
    tag_nxt.mag_in   = in_mag;
    tag_nxt.angle_in = in_angle;
    if (in_op == OP_TO_RECT) begin
      x_nxt = flip ? -m16 : m16;
      y_nxt = '0;
      z_nxt = {in_angle ^ {flip, {(FIELD_W-1){1'b0}}}, {(ANGLE_W-FIELD_W){1'b0}}};
    end else if (xe[DW-1]) begin
      x_nxt = -x16;
      y_nxt = -y16;
      z_nxt = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      x_nxt = x16;
      y_nxt = y16;
      z_nxt = '0;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_tag   = tag_r;

endmodule

[rtl/cpc_cell.sv]
// ----------------------------------------------------------------------------
// cpc_cell
// One CORDIC micro-rotation with a fixed shift, registered toward the next cell.
// ----------------------------------------------------------------------------
module cpc_cell #(
  parameter int                          SHIFT = 0,
  parameter logic [cpc_pkg::ANGLE_W-1:0] ATAN  = '0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [cpc_pkg::DW-1:0]    in_x,
  input  logic signed [cpc_pkg::DW-1:0]    in_y,
  input  logic [cpc_pkg::ANGLE_W-1:0]      in_z,
  input  cpc_pkg::cpc_tag_t                in_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cpc_pkg::DW-1:0]    out_x,
  output logic signed [cpc_pkg::DW-1:0]    out_y,
  output logic [cpc_pkg::ANGLE_W-1:0]      out_z,
  output cpc_pkg::cpc_tag_t                out_tag
);
  import cpc_pkg::*;

  logic                     valid_r;
  logic signed [DW-1:0]     x_r, x_nxt;
  logic signed [DW-1:0]     y_r, y_nxt;
  logic [ANGLE_W-1:0]       z_r, z_nxt;
  cpc_tag_t                 tag_r;
  logic signed [DW-1:0]     xs, ys;
  logic                     cw;

  // floor shifts of both coordinates
  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;

  // vectoring drives y to zero, rotation drives the residual angle to zero
  assign cw = (in_tag.op == OP_TO_RECT) ? in_z[ANGLE_W-1] : !in_y[DW-1];

  always_comb begin
    if (cw) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + ATAN;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - ATAN;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      tag_r <= in_tag;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_tag   = tag_r;

endmodule

[rtl/cpc_gain.sv]
// ----------------------------------------------------------------------------
// cpc_gain
// Removes the CORDIC gain, saturates and selects the result fields.
// ----------------------------------------------------------------------------
module cpc_gain #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [cpc_pkg::DW-1:0]    in_x,
  input  logic signed [cpc_pkg::DW-1:0]    in_y,
  input  logic [cpc_pkg::ANGLE_W-1:0]      in_z,
  input  cpc_pkg::cpc_tag_t                in_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [cpc_pkg::FIELD_W-1:0]      out_x,
  output logic [cpc_pkg::FIELD_W-1:0]      out_y,
  output logic [cpc_pkg::FIELD_W-1:0]      out_mag,
  output logic [cpc_pkg::FIELD_W-1:0]      out_angle
);
  import cpc_pkg::*;

  localparam logic signed [PW-1:0] RND    = PW'(64'sd1 <<< (GAIN_SHIFT - 1));
  localparam logic signed [PW-1:0] C_HI   = PW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] C_LO   = PW'(-(64'sd1 <<< (COORD_WIDTH - 1)));
  localparam logic signed [PW-1:0] M_HI   = PW'((64'sd1 <<< FIELD_W) - 64'sd1);

  // multiply stage
  logic                     mv_r;
  logic signed [PW-1:0]     px_r, py_r;
  logic [FIELD_W-1:0]       ang_r;
  cpc_tag_t                 tag_r;
  logic                     m_ready;
  logic [ANGLE_W-1:0]       z_rnd;

  // output stage
  logic                     ov_r;
  logic [FIELD_W-1:0]       ox_r, ox_nxt;
  logic [FIELD_W-1:0]       oy_r, oy_nxt;
  logic [FIELD_W-1:0]       om_r, om_nxt;
  logic [FIELD_W-1:0]       oa_r, oa_nxt;
  logic                     o_ready;
  logic signed [PW-1:0]     sx, sy, cx, cy;

  assign o_ready  = !ov_r || out_ready;
  assign m_ready  = !mv_r || o_ready;
  assign in_ready = m_ready;

  // angle rounded to the field
  assign z_rnd = in_z + ANGLE_W'(1 << (ANGLE_W - FIELD_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (m_ready) begin
      mv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      px_r  <= PW'(in_x) * PW'(GAIN_Q24) + RND;
      py_r  <= PW'(in_y) * PW'(GAIN_Q24) + RND;
      ang_r <= z_rnd[ANGLE_W-1 -: FIELD_W];
      tag_r <= in_tag;
    end
  end

  // scale back, clamp and pick echoed or computed fields
  assign sx = px_r >>> GAIN_SHIFT;
  assign sy = py_r >>> GAIN_SHIFT;

  always_comb begin
    cx = (sx > C_HI) ? C_HI : ((sx < C_LO) ? C_LO : sx);
    cy = (sy > C_HI) ? C_HI : ((sy < C_LO) ? C_LO : sy);
    if (tag_r.op == OP_TO_RECT) begin
      ox_nxt = cx[FIELD_W-1:0];
      oy_nxt = cy[FIELD_W-1:0];
      om_nxt = tag_r.mag_in;
      oa_nxt = tag_r.angle_in;
    end else begin
      ox_nxt = tag_r.x_in;
      oy_nxt = tag_r.y_in;
      if (tag_r.zero || sx[PW-1]) begin
        om_nxt = '0;
      end else if (sx > M_HI) begin
        om_nxt = '1;
      end else begin
        om_nxt = sx[FIELD_W-1:0];
      end
      oa_nxt = tag_r.zero ? '0 : ang_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (o_ready) begin
      ov_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && mv_r) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      om_r <= om_nxt;
      oa_r <= oa_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_mag   = om_r;
  assign out_angle = oa_r;

endmodule

[rtl/cartesian_polar_converter.sv]
// ----------------------------------------------------------------------------
// cartesian_polar_converter
// Fixed-point CORDIC converting vectors between rectangular and polar form.
// ----------------------------------------------------------------------------
// Pipeline: input stage, one cell per iteration (capped at MAX_ITERATIONS),
//   gain multiply, output register.
// Throughput: one vector per cycle unless stalled; one item per stage.
// Stalls back up stage by stage, so empty stages keep taking new items.
// Reset: synchronous active-low rst_n clears all valid flags; data is kept.
module cartesian_polar_converter #(
  parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH_DEF,
  parameter int ITERATIONS  = cpc_pkg::ITERATIONS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cpc_in_if.sink    in_if,
  cpc_out_if.source out_if
);
  import cpc_pkg::*;

  localparam int N = (ITERATIONS > MAX_ITERATIONS) ? MAX_ITERATIONS : ITERATIONS;

  // chain links: index 0 leaves the input stage, index N enters gain removal
  logic                 c_valid [N+1];
  logic                 c_ready [N+1];
  logic signed [DW-1:0] c_x     [N+1];
  logic signed [DW-1:0] c_y     [N+1];
  logic [ANGLE_W-1:0]   c_z     [N+1];
  cpc_tag_t             c_tag   [N+1];

  cpc_pre #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_op     (in_if.op),
    .in_x      (in_if.x_in),
    .in_y      (in_if.y_in),
    .in_mag    (in_if.mag_in),
    .in_angle  (in_if.angle_in),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_x     (c_x[0]),
    .out_y     (c_y[0]),
    .out_z     (c_z[0]),
    .out_tag   (c_tag[0])
  );

  // row of micro-rotation cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    cpc_cell #(
      .SHIFT (i),
      .ATAN  (atan_val(i))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_x      (c_x[i]),
      .in_y      (c_y[i]),
      .in_z      (c_z[i]),
      .in_tag    (c_tag[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_x     (c_x[i+1]),
      .out_y     (c_y[i+1]),
      .out_z     (c_z[i+1]),
      .out_tag   (c_tag[i+1])
    );
  end

  cpc_gain #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid[N]),
    .in_ready  (c_ready[N]),
    .in_x      (c_x[N]),
    .in_y      (c_y[N]),
    .in_z      (c_z[N]),
    .in_tag    (c_tag[N]),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_x     (out_if.x_out),
    .out_y     (out_if.y_out),
    .out_mag   (out_if.mag_out),
    .out_angle (out_if.angle_out)
  );

endmodule
